FILE: rtl/frame_builder_bit_stuffing_serializer_top_macros.svh
// assertion macros used by the framer datapath
`ifndef FRAME_BUILDER_BIT_STUFFING_SERIALIZER_TOP_MACROS_SVH
`define FRAME_BUILDER_BIT_STUFFING_SERIALIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clock, off during reset
`define FBBS_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fbbs check failed");

// next-cycle implication, sampled on clock, off during reset
`define FBBS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fbbs check failed");

`else

`define FBBS_ASSERT_IMPL(name, ante, cons)
`define FBBS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: rtl/fbbs_pkg.sv
`timescale 1ns / 1ps

package fbbs_pkg;

   localparam int FRAME_BITS      = 13;
   localparam int STUFF_ZONE_BITS = 9;
   localparam int TRAILER_BITS    = 4;
   localparam int SEL_W           = 3;
   localparam int TX_BITS         = FRAME_BITS + TRAILER_BITS;
   localparam int POS_W           = $clog2(TX_BITS);

   localparam logic [FRAME_BITS-1:0]   HEADER_WORD  = FRAME_BITS'(5632);
   localparam logic [TRAILER_BITS-1:0] TRAILER_WORD = TRAILER_BITS'(10);

   localparam logic [FRAME_BITS-1:0] MASK_CLEAR_BIT0 = FRAME_BITS'(8190);
   localparam logic [FRAME_BITS-1:0] MASK_CLEAR_BIT1 = FRAME_BITS'(8189);
   localparam logic [FRAME_BITS-1:0] MASK_ENDS       = FRAME_BITS'(7683);
   localparam logic [FRAME_BITS-1:0] MASK_LOW9       = FRAME_BITS'(511);

   // positions within one transmit, header bits first
   localparam logic [POS_W-1:0] ZONE_START_POS = POS_W'(FRAME_BITS - STUFF_ZONE_BITS);
   localparam logic [POS_W-1:0] ZONE_END_POS   = POS_W'(FRAME_BITS);
   localparam logic [POS_W-1:0] LAST_POS       = POS_W'(TX_BITS - 1);

   localparam logic CMD_UPDATE   = 1'b0;
   localparam logic CMD_TRANSMIT = 1'b1;

   localparam logic [SEL_W-1:0] SEL_LOW9       = SEL_W'(1);
   localparam logic [SEL_W-1:0] SEL_ENDS       = SEL_W'(2);
   localparam logic [SEL_W-1:0] SEL_CLEAR_BIT1 = SEL_W'(3);
   localparam logic [SEL_W-1:0] SEL_CLEAR_BIT0 = SEL_W'(4);

   // progress of the 1011 tracker
   localparam logic [1:0] PROG_NONE = 2'd0;
   localparam logic [1:0] PROG_1    = 2'd1;
   localparam logic [1:0] PROG_10   = 2'd2;
   localparam logic [1:0] PROG_101  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_TRANSMIT
   } fbbs_state_type;

   typedef struct packed {
      logic capture;
      logic do_update;
      logic tx_step;
   } fbbs_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic tx_final;
   } fbbs_status_type;

   function automatic logic [1:0] track_next(input logic [1:0] prog, input logic bit_val);
      logic [1:0] nxt;
      case (prog)
         PROG_NONE: nxt = bit_val ? PROG_1 : PROG_NONE;
         PROG_1:    nxt = bit_val ? PROG_1 : PROG_10;
         PROG_10:   nxt = bit_val ? PROG_101 : PROG_NONE;
         default:   nxt = bit_val ? PROG_NONE : PROG_10;
      endcase
      return nxt;
   endfunction

endpackage

FILE: rtl/fbbs_if.sv
`timescale 1ns / 1ps

interface fbbs_req_if import fbbs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [SEL_W-1:0]      field_select;
   logic [FRAME_BITS-1:0] field_value;
   logic                  keep_frame;

   modport source (output valid, output command, output field_select,
                   output field_value, output keep_frame, input ready);
   modport sink   (input valid, input command, input field_select,
                   input field_value, input keep_frame, output ready);
endinterface

interface fbbs_rsp_if import fbbs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  bit_present;
   logic                  line_bit;
   logic                  is_stuffed;
   logic [FRAME_BITS-1:0] frame_word;
   logic                  last;

   modport source (output valid, output bit_present, output line_bit,
                   output is_stuffed, output frame_word, output last, input ready);
   modport sink   (input valid, input bit_present, input line_bit,
                   input is_stuffed, input frame_word, input last, output ready);
endinterface

FILE: rtl/fbbs_ctrl.sv
`timescale 1ns / 1ps

module fbbs_ctrl import fbbs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_command,
   output logic            req_ready,
   input  fbbs_status_type status,
   output fbbs_cmd_type    cmd
);

   fbbs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_command == CMD_TRANSMIT) ? ST_TRANSMIT : ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (status.slot_free) begin
               cmd.do_update = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_TRANSMIT: begin
            if (status.slot_free) begin
               cmd.tx_step = 1'b1;
               if (status.tx_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/fbbs_dp.sv
`timescale 1ns / 1ps
`include "frame_builder_bit_stuffing_serializer_top_macros.svh"

module fbbs_dp import fbbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  fbbs_cmd_type          cmd,
   output fbbs_status_type       status,
   input  logic [SEL_W-1:0]      req_field_select,
   input  logic [FRAME_BITS-1:0] req_field_value,
   input  logic                  req_keep_frame,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_bit_present,
   output logic                  rsp_line_bit,
   output logic                  rsp_is_stuffed,
   output logic [FRAME_BITS-1:0] rsp_frame_word,
   output logic                  rsp_last
);

   // latched request
   logic [SEL_W-1:0]      sel_ff;
   logic [FRAME_BITS-1:0] value_ff;
   logic                  keep_ff;

   logic [FRAME_BITS-1:0] held_ff, held_in;
   logic [TX_BITS-1:0]    shift_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [1:0]            prog_ff;

   logic                  valid_ff;
   logic                  present_ff;
   logic                  line_ff;
   logic                  stuffed_ff;
   logic [FRAME_BITS-1:0] word_ff;
   logic                  last_ff;

   logic cur_bit;
   logic in_zone;
   logic stuff_now;
   logic tx_final;

   assign cur_bit   = shift_ff[TX_BITS-1];
   assign in_zone   = (pos_ff >= ZONE_START_POS) && (pos_ff < ZONE_END_POS);
   assign stuff_now = in_zone && cur_bit && (prog_ff == PROG_101);
   assign tx_final  = (pos_ff == LAST_POS);

   assign status.slot_free = !valid_ff || rsp_ready;
   assign status.tx_final  = tx_final;

   // merge or restart
   always_comb begin
      held_in = held_ff;
      if (!keep_ff) begin
         held_in = HEADER_WORD | value_ff;
      end else begin
         case (sel_ff)
            SEL_CLEAR_BIT0: held_in = (held_ff & MASK_CLEAR_BIT0) | value_ff;
            SEL_CLEAR_BIT1: held_in = (held_ff & MASK_CLEAR_BIT1) | value_ff;
            SEL_ENDS:       held_in = (held_ff & MASK_ENDS) | value_ff;
            SEL_LOW9:       held_in = (held_ff & MASK_LOW9) | value_ff;
            default:        held_in = held_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sel_ff   <= req_field_select;
         value_ff <= req_field_value;
         keep_ff  <= req_keep_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         shift_ff <= '0;
         pos_ff   <= '0;
         prog_ff  <= PROG_NONE;
      end else begin
         if (cmd.capture) begin
            shift_ff <= {held_ff, TRAILER_WORD};
            pos_ff   <= '0;
            prog_ff  <= PROG_NONE;
         end else if (cmd.do_update) begin
            held_ff <= held_in;
         end else if (cmd.tx_step) begin
            if (stuff_now) begin
               prog_ff <= track_next(prog_ff, 1'b0);
            end else begin
               shift_ff <= {shift_ff[TX_BITS-2:0], 1'b0};
               pos_ff   <= pos_ff + POS_W'(1);
               if (in_zone) begin
                  prog_ff <= track_next(prog_ff, cur_bit);
               end
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.do_update || cmd.tx_step) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_update) begin
         present_ff <= 1'b0;
         line_ff    <= 1'b0;
         stuffed_ff <= 1'b0;
         word_ff    <= held_in;
         last_ff    <= 1'b1;
      end else if (cmd.tx_step) begin
         present_ff <= 1'b1;
         line_ff    <= stuff_now ? 1'b0 : cur_bit;
         stuffed_ff <= stuff_now;
         word_ff    <= held_ff;
         last_ff    <= tx_final && !stuff_now;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_bit_present = present_ff;
   assign rsp_line_bit    = line_ff;
   assign rsp_is_stuffed  = stuffed_ff;
   assign rsp_frame_word  = word_ff;
   assign rsp_last        = last_ff;

   `FBBS_ASSERT_NEXT(a_stuff_resumes_at_10, cmd.tx_step && stuff_now, prog_ff == PROG_10)
   `FBBS_ASSERT_IMPL(a_no_stuff_outside_zone, cmd.tx_step && !in_zone, !stuff_now)
   `FBBS_ASSERT_NEXT(a_final_bit_is_last, cmd.tx_step && tx_final, valid_ff && last_ff && present_ff)
   `FBBS_ASSERT_IMPL(a_stuffed_is_zero_bit, valid_ff && stuffed_ff, present_ff && !line_ff && !last_ff)

endmodule

FILE: rtl/frame_builder_bit_stuffing_serializer_top.sv
// bit stuffing framer: holds a 13-bit frame, updates it and serializes it
// request channel (req_chan): command 0 updates the frame (new frame with
//   header 1011 or masked merge), command 1 transmits the held frame
// response channel (rsp_chan): an update gives one acknowledgement with
//   last set; a transmit gives 17 to 23 line bits, msb first, with stuffed
//   zeros in the low 9 payload bits and the trailer 1010, last on the final bit
// rate: one response per cycle in a transmit, from a single output register,
//   while the receiver is ready; an update goes from accept via the update
//   state to the output register; a transmit is paced by the controller giving
//   one serializer step per emitted bit; a stuffed zero holds the shift register
// the next request is accepted as soon as the controller is back in idle,
//   even while the final response of the previous request still waits
// reset clears the held frame to zero, the tracker and the output valid
// a stalled receiver freezes the controller: no bit advances until the
//   output register is taken, so nothing is dropped or repeated
`timescale 1ns / 1ps

module frame_builder_bit_stuffing_serializer_top import fbbs_pkg::*; (
   input logic         clock,
   input logic         reset,
   fbbs_req_if.sink    req_chan,
   fbbs_rsp_if.source  rsp_chan
);

   fbbs_cmd_type    cmd;
   fbbs_status_type status;

   // sequencer: idle, update, transmit
   fbbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // frame register, serializer, 1011 tracker and output register
   fbbs_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_field_select (req_chan.field_select),
      .req_field_value  (req_chan.field_value),
      .req_keep_frame   (req_chan.keep_frame),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_bit_present  (rsp_chan.bit_present),
      .rsp_line_bit     (rsp_chan.line_bit),
      .rsp_is_stuffed   (rsp_chan.is_stuffed),
      .rsp_frame_word   (rsp_chan.frame_word),
      .rsp_last         (rsp_chan.last)
   );

endmodule

FILE: tb/sv/frame_builder_bit_stuffing_serializer_top_test.sv
`timescale 1ns / 1ps

module frame_builder_bit_stuffing_serializer_top_test;
   import fbbs_pkg::*;

   // run length and pacing
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 50;
   localparam int RANDOM_REQUESTS = 97;
   localparam int PRESSURE_AT     = 60;   // request count that triggers the long hold-off
   localparam int PRESSURE_CYCLES = 400;
   localparam int CALM_FIRST      = 80;   // random requests in this span run with no idling
   localparam int CALM_LAST       = 100;

   // keep_frame codes
   localparam logic KEEP_NEW   = 1'b0;
   localparam logic KEEP_MERGE = 1'b1;

   // field selects with no mask behind them
   localparam logic [SEL_W-1:0] SEL_SPARE_0 = SEL_W'(0);
   localparam logic [SEL_W-1:0] SEL_SPARE_5 = SEL_W'(5);
   localparam logic [SEL_W-1:0] SEL_SPARE_6 = SEL_W'(6);
   localparam logic [SEL_W-1:0] SEL_SPARE_7 = SEL_W'(7);

   localparam int HEAD_BITS = FRAME_BITS - STUFF_ZONE_BITS;

   // one response as seen on the line
   typedef struct packed {
      logic                  bit_present;
      logic                  line_bit;
      logic                  is_stuffed;
      logic [FRAME_BITS-1:0] frame_word;
      logic                  last;
   } line_word_type;

   // one request, with an optional hand-computed frame for the update ack
   typedef struct {
      logic                  command;
      logic [SEL_W-1:0]      field_select;
      logic [FRAME_BITS-1:0] field_value;
      logic                  keep_frame;
      bit                    typed;
      logic [FRAME_BITS-1:0] typed_frame;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 23;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // transmit of the reset frame: all zeros, no stuffing
      '{CMD_TRANSMIT, SEL_SPARE_0,    13'd0,    KEEP_NEW,   1'b0, 13'd0},
      // merging zero leaves the reset frame alone
      '{CMD_UPDATE,   SEL_LOW9,       13'd0,    KEEP_MERGE, 1'b1, 13'd0},
      // new frame carries only the header
      '{CMD_UPDATE,   SEL_SPARE_0,    13'd0,    KEEP_NEW,   1'b1, 13'd5632},
      // transmit ignores its other fields
      '{CMD_TRANSMIT, SEL_SPARE_7,    13'd8191, KEEP_MERGE, 1'b0, 13'd0},
      // new frame ignores the select, all ones
      '{CMD_UPDATE,   SEL_SPARE_7,    13'd8191, KEEP_NEW,   1'b1, 13'd8191},
      '{CMD_TRANSMIT, SEL_LOW9,       13'd0,    KEEP_NEW,   1'b0, 13'd0},
      // each mask in turn, merging nothing until the low-9 mask merges 5
      '{CMD_UPDATE,   SEL_CLEAR_BIT0, 13'd0,    KEEP_MERGE, 1'b1, 13'd8190},
      '{CMD_UPDATE,   SEL_CLEAR_BIT1, 13'd0,    KEEP_MERGE, 1'b1, 13'd8188},
      '{CMD_UPDATE,   SEL_ENDS,       13'd0,    KEEP_MERGE, 1'b1, 13'd7680},
      '{CMD_UPDATE,   SEL_LOW9,       13'd5,    KEEP_MERGE, 1'b1, 13'd5},
      // unknown selects leave the held frame untouched
      '{CMD_UPDATE,   SEL_SPARE_0,    13'd8191, KEEP_MERGE, 1'b1, 13'd5},
      '{CMD_UPDATE,   SEL_SPARE_5,    13'd8191, KEEP_MERGE, 1'b1, 13'd5},
      '{CMD_UPDATE,   SEL_SPARE_6,    13'd4096, KEEP_MERGE, 1'b1, 13'd5},
      '{CMD_UPDATE,   SEL_SPARE_7,    13'd1,    KEEP_MERGE, 1'b1, 13'd5},
      '{CMD_TRANSMIT, SEL_CLEAR_BIT0, 13'd0,    KEEP_MERGE, 1'b0, 13'd0},
      // zone 101 then six ones: a stuffed zero before every one after the 101
      '{CMD_UPDATE,   SEL_SPARE_0,    13'd383,  KEEP_NEW,   1'b1, 13'd6015},
      '{CMD_TRANSMIT, SEL_SPARE_0,    13'd0,    KEEP_NEW,   1'b0, 13'd0},
      // zone 101101101: pattern completes twice
      '{CMD_UPDATE,   SEL_ENDS,       13'd365,  KEEP_NEW,   1'b1, 13'd5997},
      '{CMD_TRANSMIT, SEL_SPARE_0,    13'd0,    KEEP_NEW,   1'b0, 13'd0},
      // back to back: the detector starts over for every transmit
      '{CMD_TRANSMIT, SEL_SPARE_0,    13'd0,    KEEP_NEW,   1'b0, 13'd0},
      '{CMD_UPDATE,   SEL_ENDS,       13'd8191, KEEP_MERGE, 1'b1, 13'd8191},
      '{CMD_UPDATE,   SEL_LOW9,       13'd0,    KEEP_MERGE, 1'b1, 13'd511},
      // header zeros, zone all ones: ones alone never stuff
      '{CMD_TRANSMIT, SEL_SPARE_0,    13'd0,    KEEP_NEW,   1'b0, 13'd0}
   };

   logic clock;
   logic reset;

   fbbs_req_if req_chan ();
   fbbs_rsp_if rsp_chan ();

   frame_builder_bit_stuffing_serializer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state: the frame the block should hold and the 1011 tracker
   logic [FRAME_BITS-1:0] model_frame;
   logic [1:0]            model_progress;
   line_word_type         awaited_outputs [$];

   int  mismatch_count = 0;
   int  requests_taken = 0;
   int  cycle_count    = 0;
   int  rsp_stall      = 0;
   bit  pressure_done  = 1'b0;
   bit  calm           = 1'b0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // next tracker progress after emitting one zone bit
   function automatic logic [1:0] next_progress(input logic [1:0] progress, input logic b);
      case (progress)
         PROG_NONE: return b ? PROG_1 : PROG_NONE;
         PROG_1:    return b ? PROG_1 : PROG_10;
         PROG_10:   return b ? PROG_101 : PROG_NONE;
         default:   return b ? PROG_NONE : PROG_10;  // a one here is always stuffed first
      endcase
   endfunction

   // idle length for either side: mostly none, some short, a few long
   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 19);
      if (calm || roll < 12) return 0;
      if (roll < 18) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   // zone contents rich in 1011, with an occasional flipped bit
   function automatic logic [STUFF_ZONE_BITS-1:0] patterned_zone();
      logic [STUFF_ZONE_BITS-1:0] zone;
      int                         idx;
      case ($urandom_range(0, 5))
         0:       zone = 9'b101111111;
         1:       zone = 9'b101101101;
         2:       zone = 9'b110110110;
         3:       zone = 9'b011011011;
         4:       zone = 9'b101011011;
         default: zone = STUFF_ZONE_BITS'($urandom);
      endcase
      if ($urandom_range(0, 2) == 0) begin
         idx = $urandom_range(0, STUFF_ZONE_BITS - 1);
         zone[idx] = ~zone[idx];
      end
      return zone;
   endfunction

   // apply one accepted request to the predictor and queue what it yields
   task automatic predict_request(input stim_row_type row);
      logic b;
      if (row.command == CMD_UPDATE) begin
         if (row.keep_frame == KEEP_NEW) begin
            model_frame = HEADER_WORD | row.field_value;
         end else begin
            case (row.field_select)
               SEL_CLEAR_BIT0: model_frame = (model_frame & MASK_CLEAR_BIT0) | row.field_value;
               SEL_CLEAR_BIT1: model_frame = (model_frame & MASK_CLEAR_BIT1) | row.field_value;
               SEL_ENDS:       model_frame = (model_frame & MASK_ENDS) | row.field_value;
               SEL_LOW9:       model_frame = (model_frame & MASK_LOW9) | row.field_value;
               default: ;
            endcase
         end
         awaited_outputs.push_back(line_word_type'{1'b0, 1'b0, 1'b0, model_frame, 1'b1});
      end else begin
         model_progress = PROG_NONE;
         for (int i = FRAME_BITS - 1; i >= 0; i--) begin
            b = model_frame[i];
            if (i < STUFF_ZONE_BITS) begin
               // a one that would complete 1011 gets a zero in front of it
               if (b && model_progress == PROG_101) begin
                  awaited_outputs.push_back(
                     line_word_type'{1'b1, 1'b0, 1'b1, model_frame, 1'b0});
                  model_progress = next_progress(model_progress, 1'b0);
               end
               model_progress = next_progress(model_progress, b);
            end
            awaited_outputs.push_back(line_word_type'{1'b1, b, 1'b0, model_frame, 1'b0});
         end
         for (int i = TRAILER_BITS - 1; i >= 0; i--) begin
            awaited_outputs.push_back(
               line_word_type'{1'b1, TRAILER_WORD[i], 1'b0, model_frame, i == 0});
         end
      end
   endtask

   // offer one request after a random gap and wait for the handshake
   task automatic send_request(input stim_row_type row);
      int            gap;
      line_word_type ack;
      gap = idle_span();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= row.command;
      req_chan.field_select <= row.field_select;
      req_chan.field_value  <= row.field_value;
      req_chan.keep_frame   <= row.keep_frame;
      do @(posedge clock); while (!req_chan.ready);
      requests_taken++;
      predict_request(row);
      // hand-computed rows pin the acknowledged frame directly
      if (row.typed) begin
         ack = awaited_outputs.pop_back();
         ack.frame_word = row.typed_frame;
         awaited_outputs.push_back(ack);
      end
   endtask

   // random request: mostly transmits and well-formed frames, some noise
   task automatic send_random_request();
      stim_row_type row;
      int           roll;
      roll             = $urandom_range(0, 9);
      row.command      = CMD_UPDATE;
      row.field_select = SEL_W'($urandom);
      row.field_value  = FRAME_BITS'($urandom);
      row.keep_frame   = 1'($urandom);
      row.typed        = 1'b0;
      row.typed_frame  = '0;
      if (roll <= 3) begin
         row.command = CMD_TRANSMIT;
      end else if (roll <= 6) begin
         // fresh frame with a stuffing-heavy zone, header bits sometimes set
         row.keep_frame  = KEEP_NEW;
         row.field_value = {($urandom_range(0, 3) == 0) ? HEAD_BITS'($urandom) : HEAD_BITS'(0),
                            patterned_zone()};
      end else if (roll <= 8) begin
         // sparse merge under a real mask so the frame does not saturate
         row.keep_frame   = KEEP_MERGE;
         row.field_select = SEL_W'($urandom_range(SEL_LOW9, SEL_CLEAR_BIT0));
         row.field_value  = FRAME_BITS'($urandom & $urandom & $urandom);
      end else begin
         row.keep_frame = KEEP_MERGE;
      end
      send_request(row);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // response receiver: random stalls, one long hold-off to back up the block
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!pressure_done && requests_taken >= PRESSURE_AT) begin
            rsp_stall     = PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end
         if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
            rsp_stall = idle_span();
         end
      end
   end

   // response checker: each taken response against the oldest prediction
   always @(posedge clock) begin
      line_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_outputs.size() == 0) begin
            $display("%0t: response with nothing pending, expected none actual frame_word %0d",
                     $time, rsp_chan.frame_word);
            mismatch_count++;
         end else begin
            want = awaited_outputs.pop_front();
            check_field("bit_present", 16'(want.bit_present), 16'(rsp_chan.bit_present));
            check_field("line_bit", 16'(want.line_bit), 16'(rsp_chan.line_bit));
            check_field("is_stuffed", 16'(want.is_stuffed), 16'(rsp_chan.is_stuffed));
            check_field("frame_word", 16'(want.frame_word), 16'(rsp_chan.frame_word));
            check_field("last", 16'(want.last), 16'(rsp_chan.last));
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("frame_builder_bit_stuffing_serializer_top: mismatch");
      $finish;
   end

   // reset, directed table, random requests, drain
   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.command      = CMD_UPDATE;
      req_chan.field_select = SEL_SPARE_0;
      req_chan.field_value  = '0;
      req_chan.keep_frame   = KEEP_NEW;
      model_frame           = '0;
      model_progress        = PROG_NONE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_request(directed_rows[r]);
      end

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         calm = (n >= CALM_FIRST && n < CALM_LAST);
         send_random_request();
      end
      calm = 1'b0;
      req_chan.valid <= 1'b0;

      // wait for every predicted response, then watch for strays
      while (awaited_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("frame_builder_bit_stuffing_serializer_top: match");
      end else begin
         $display("frame_builder_bit_stuffing_serializer_top: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/fbbs_pkg.sv
rtl/fbbs_if.sv
rtl/fbbs_ctrl.sv
rtl/fbbs_dp.sv
rtl/frame_builder_bit_stuffing_serializer_top.sv
tb/sv/frame_builder_bit_stuffing_serializer_top_test.sv
